/* rtl/mps_pkg.sv */
package mps_pkg;

  localparam int unsigned DelayBitsDefault    = 16;
  localparam int unsigned PlayTimeBitsDefault = 32;

  localparam int unsigned FuncW    = 3;
  localparam int unsigned ElapsedW = 10;
  localparam int unsigned CfgW     = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned OutTimeW = 32;

  typedef enum logic [2:0] {
    FUNC_TICK            = 3'd0,
    FUNC_ON              = 3'd1,
    FUNC_READY           = 3'd2,
    FUNC_READY_NO_ORIGIN = 3'd3,
    FUNC_PLAY            = 3'd4,
    FUNC_STOP            = 3'd5,
    FUNC_OFF             = 3'd6
  } func_e;

  typedef enum logic [2:0] {
    MAIN_OFF        = 3'd0,
    MAIN_INIT       = 3'd1,
    MAIN_READY      = 3'd2,
    MAIN_READY_PLAY = 3'd3,
    MAIN_PLAY       = 3'd4,
    MAIN_READY_STOP = 3'd5,
    MAIN_END        = 3'd6
  } main_e;

  typedef enum logic [3:0] {
    SUB_OFF          = 4'd0,
    SUB_START_MOTION = 4'd1,
    SUB_INIT         = 4'd2,
    SUB_START        = 4'd3,
    SUB_ORIGIN       = 4'd4,
    SUB_ORIGIN_STOP  = 4'd5,
    SUB_STOP_READY   = 4'd6,
    SUB_READY        = 4'd7,
    SUB_LOAD         = 4'd8,
    SUB_PLAYING      = 4'd9,
    SUB_END          = 4'd10,
    SUB_END_STOP     = 4'd11,
    SUB_RESTART      = 4'd12,
    SUB_STOP_MOTION  = 4'd13,
    SUB_STOP         = 4'd14,
    SUB_DELAY        = 4'd15
  } sub_e;

  typedef enum logic [1:0] {
    CMD_SERVO_ON  = 2'd0,
    CMD_START     = 2'd1,
    CMD_STOP      = 2'd2,
    CMD_SERVO_OFF = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    CFG_SERVO_ON_WAIT  = 3'd0,
    CFG_START_WAIT     = 3'd1,
    CFG_ORIGIN_WAIT    = 3'd2,
    CFG_STOP_WAIT      = 3'd3,
    CFG_END_WAIT       = 3'd4,
    CFG_SERVO_OFF_WAIT = 3'd5
  } cfg_idx_e;

  localparam logic [CfgW-1:0] ServoOnWaitRst  = 16'd1000;
  localparam logic [CfgW-1:0] StartWaitRst    = 16'd100;
  localparam logic [CfgW-1:0] OriginWaitRst   = 16'd500;
  localparam logic [CfgW-1:0] StopWaitRst     = 16'd3000;
  localparam logic [CfgW-1:0] EndWaitRst      = 16'd1000;
  localparam logic [CfgW-1:0] ServoOffWaitRst = 16'd1000;

endpackage

/* rtl/mps_if.sv */
interface mps_in_if;
  logic                            valid;
  logic                            ready;
  logic [mps_pkg::FuncW-1:0]       func;
  logic [mps_pkg::ElapsedW-1:0]    elapsed_ms;

  modport source (output valid, output func, output elapsed_ms, input ready);
  modport sink   (input valid, input func, input elapsed_ms, output ready);
endinterface

interface mps_out_if;
  logic                            valid;
  logic                            ready;
  logic [2:0]                      main_state;
  logic [3:0]                      step_code;
  logic                            play_accepted;
  logic                            command_valid;
  logic [1:0]                      command_code;
  logic [mps_pkg::OutTimeW-1:0]    play_time_ms;

  modport source (output valid, output main_state, output step_code, output play_accepted,
                  output command_valid, output command_code, output play_time_ms,
                  input ready);
  modport sink   (input valid, input main_state, input step_code, input play_accepted,
                  input command_valid, input command_code, input play_time_ms,
                  output ready);
endinterface

/* rtl/motion_platform_sequencer_core.sv */
// Each input transfer's result is registered in the output register.
// Throughput: one item per cycle while the output is not stalled; the state update is a single
// combinational pass between the sequencer state registers and the output register.
// A new item is taken while the output register is empty or being drained.
// Reset (rst_ni low, asynchronous): state returns to off, delay and play time clear,
// wait registers take their default values and the output register empties.
module motion_platform_sequencer_core #(
  parameter int unsigned DELAY_BITS     = mps_pkg::DelayBitsDefault,
  parameter int unsigned PLAY_TIME_BITS = mps_pkg::PlayTimeBitsDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  mps_in_if.sink                       in_i,
  mps_out_if.source                    out_o,
  input  logic                         cfg_we_i,
  input  logic [mps_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [mps_pkg::CfgW-1:0]     cfg_data_i
);

  localparam int unsigned CmpW = (DELAY_BITS > mps_pkg::ElapsedW) ? DELAY_BITS
                                                                   : mps_pkg::ElapsedW;
  localparam int unsigned LdW  = (DELAY_BITS > mps_pkg::CfgW) ? DELAY_BITS : mps_pkg::CfgW;
  localparam int unsigned PtxW = (PLAY_TIME_BITS > mps_pkg::OutTimeW) ? PLAY_TIME_BITS
                                                                       : mps_pkg::OutTimeW;

  // wait registers
  logic [mps_pkg::CfgW-1:0] servo_on_wait_q, start_wait_q, origin_wait_q;
  logic [mps_pkg::CfgW-1:0] stop_wait_q, end_wait_q, servo_off_wait_q;

  // sequencer state
  mps_pkg::main_e              mode_q, mode_d;
  mps_pkg::sub_e               step_q, step_d;
  mps_pkg::sub_e               next_q, next_d;
  logic [DELAY_BITS-1:0]       rem_q, rem_d;
  logic [PLAY_TIME_BITS-1:0]   pt_q, pt_d;

  // output register
  logic                        out_valid_q;
  mps_pkg::main_e              res_main_q;
  mps_pkg::sub_e               res_sub_q;
  logic                        res_acc_q, acc_d;
  logic                        res_cmd_v_q, cmd_v_d;
  mps_pkg::cmd_e               res_cmd_q, cmd_d;
  logic [mps_pkg::OutTimeW-1:0] res_pt_q;

  logic                        accept;
  mps_pkg::func_e              func;
  logic [CmpW-1:0]             rem_ext, el_ext;
  logic [PLAY_TIME_BITS:0]     pt_sum;
  logic                        ld_en;
  logic [mps_pkg::CfgW-1:0]    ld_val;
  mps_pkg::sub_e               ld_next;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign func       = mps_pkg::func_e'(in_i.func);
  assign rem_ext    = CmpW'(rem_q);
  assign el_ext     = CmpW'(in_i.elapsed_ms);
  assign pt_sum     = (PLAY_TIME_BITS + 1)'(pt_q) + (PLAY_TIME_BITS + 1)'(in_i.elapsed_ms);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      servo_on_wait_q  <= mps_pkg::ServoOnWaitRst;
      start_wait_q     <= mps_pkg::StartWaitRst;
      origin_wait_q    <= mps_pkg::OriginWaitRst;
      stop_wait_q      <= mps_pkg::StopWaitRst;
      end_wait_q       <= mps_pkg::EndWaitRst;
      servo_off_wait_q <= mps_pkg::ServoOffWaitRst;
    end else if (cfg_we_i) begin
      case (mps_pkg::cfg_idx_e'(cfg_idx_i))
        mps_pkg::CFG_SERVO_ON_WAIT:  servo_on_wait_q  <= cfg_data_i;
        mps_pkg::CFG_START_WAIT:     start_wait_q     <= cfg_data_i;
        mps_pkg::CFG_ORIGIN_WAIT:    origin_wait_q    <= cfg_data_i;
        mps_pkg::CFG_STOP_WAIT:      stop_wait_q      <= cfg_data_i;
        mps_pkg::CFG_END_WAIT:       end_wait_q       <= cfg_data_i;
        mps_pkg::CFG_SERVO_OFF_WAIT: servo_off_wait_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    mode_d  = mode_q;
    step_d  = step_q;
    next_d  = next_q;
    rem_d   = rem_q;
    pt_d    = pt_q;
    acc_d   = 1'b0;
    cmd_v_d = 1'b0;
    cmd_d   = mps_pkg::CMD_SERVO_ON;
    ld_en   = 1'b0;
    ld_val  = '0;
    ld_next = mps_pkg::SUB_OFF;

    case (func)
      mps_pkg::FUNC_TICK: begin
        case (step_q)
          mps_pkg::SUB_OFF:   mode_d = mps_pkg::MAIN_OFF;
          mps_pkg::SUB_INIT: begin
            cmd_v_d = 1'b1;
            cmd_d   = mps_pkg::CMD_SERVO_ON;
            ld_en   = 1'b1;
            ld_val  = servo_on_wait_q;
            ld_next = mps_pkg::SUB_STOP_READY;
          end
          mps_pkg::SUB_START: begin
            mode_d  = mps_pkg::MAIN_READY_PLAY;
            cmd_v_d = 1'b1;
            cmd_d   = mps_pkg::CMD_START;
            ld_en   = 1'b1;
            ld_val  = start_wait_q;
            ld_next = mps_pkg::SUB_PLAYING;
          end
          mps_pkg::SUB_ORIGIN: begin
            ld_en   = 1'b1;
            ld_next = mps_pkg::SUB_READY;
          end
          mps_pkg::SUB_ORIGIN_STOP: begin
            ld_en   = 1'b1;
            ld_val  = origin_wait_q;
            ld_next = mps_pkg::SUB_STOP_READY;
          end
          mps_pkg::SUB_STOP_READY: begin
            cmd_v_d = 1'b1;
            cmd_d   = mps_pkg::CMD_STOP;
            ld_en   = 1'b1;
            ld_val  = stop_wait_q;
            ld_next = mps_pkg::SUB_READY;
          end
          mps_pkg::SUB_READY: mode_d = mps_pkg::MAIN_READY;
          mps_pkg::SUB_LOAD: begin
            ld_en   = 1'b1;
            ld_val  = start_wait_q;
            ld_next = mps_pkg::SUB_START;
          end
          mps_pkg::SUB_PLAYING: begin
            mode_d = mps_pkg::MAIN_PLAY;
            // carry out means the sum passed the top of the range
            pt_d   = pt_sum[PLAY_TIME_BITS] ? '1 : pt_sum[PLAY_TIME_BITS-1:0];
          end
          mps_pkg::SUB_END: begin
            ld_en   = 1'b1;
            ld_val  = end_wait_q;
            ld_next = mps_pkg::SUB_END_STOP;
          end
          mps_pkg::SUB_END_STOP: begin
            cmd_v_d = 1'b1;
            cmd_d   = mps_pkg::CMD_STOP;
            ld_en   = 1'b1;
            ld_val  = stop_wait_q;
            ld_next = mps_pkg::SUB_STOP;
          end
          mps_pkg::SUB_STOP: begin
            cmd_v_d = 1'b1;
            cmd_d   = mps_pkg::CMD_SERVO_OFF;
            ld_en   = 1'b1;
            ld_val  = servo_off_wait_q;
            ld_next = mps_pkg::SUB_OFF;
          end
          mps_pkg::SUB_DELAY: begin
            // leaves once the remaining time would drop below zero
            if (el_ext > rem_ext) begin
              step_d = next_q;
            end else begin
              rem_d = DELAY_BITS'(rem_ext - el_ext);
            end
          end
          mps_pkg::SUB_START_MOTION: step_d = mps_pkg::SUB_INIT;
          mps_pkg::SUB_STOP_MOTION:  step_d = mps_pkg::SUB_END;
          default: ;
        endcase
      end
      mps_pkg::FUNC_ON: begin
        mode_d = mps_pkg::MAIN_INIT;
        step_d = mps_pkg::SUB_START_MOTION;
      end
      mps_pkg::FUNC_READY: begin
        mode_d = mps_pkg::MAIN_READY_STOP;
        step_d = mps_pkg::SUB_ORIGIN_STOP;
        pt_d   = '0;
      end
      mps_pkg::FUNC_READY_NO_ORIGIN: begin
        pt_d    = '0;
        ld_en   = 1'b1;
        ld_val  = start_wait_q;
        ld_next = mps_pkg::SUB_STOP_READY;
      end
      mps_pkg::FUNC_PLAY: begin
        case (mode_q)
          mps_pkg::MAIN_READY_PLAY: acc_d = 1'b1;
          mps_pkg::MAIN_READY_STOP: begin
            // restarts but reports not accepted
            mode_d = mps_pkg::MAIN_READY_PLAY;
            step_d = mps_pkg::SUB_START;
          end
          mps_pkg::MAIN_PLAY: begin
            acc_d = 1'b1;
            if (step_q == mps_pkg::SUB_DELAY) begin
              step_d = mps_pkg::SUB_START;
            end
          end
          mps_pkg::MAIN_READY: begin
            acc_d  = 1'b1;
            mode_d = mps_pkg::MAIN_READY_PLAY;
            step_d = mps_pkg::SUB_START;
          end
          default: ;
        endcase
      end
      mps_pkg::FUNC_STOP: begin
        if (mode_q == mps_pkg::MAIN_READY_PLAY || mode_q == mps_pkg::MAIN_PLAY) begin
          mode_d = mps_pkg::MAIN_READY_STOP;
          step_d = mps_pkg::SUB_ORIGIN_STOP;
          pt_d   = '0;
        end
      end
      mps_pkg::FUNC_OFF: begin
        mode_d = mps_pkg::MAIN_END;
        step_d = mps_pkg::SUB_STOP_MOTION;
      end
      default: ;
    endcase

    if (ld_en) begin
      step_d = mps_pkg::SUB_DELAY;
      rem_d  = DELAY_BITS'(LdW'(ld_val));
      next_d = ld_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= mps_pkg::MAIN_OFF;
      step_q      <= mps_pkg::SUB_OFF;
      next_q      <= mps_pkg::SUB_OFF;
      rem_q       <= '0;
      pt_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        mode_q <= mode_d;
        step_q <= step_d;
        next_q <= next_d;
        rem_q  <= rem_d;
        pt_q   <= pt_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_main_q  <= mode_d;
      res_sub_q   <= step_d;
      res_acc_q   <= acc_d;
      res_cmd_v_q <= cmd_v_d;
      res_cmd_q   <= cmd_d;
      res_pt_q    <= mps_pkg::OutTimeW'(PtxW'(pt_d));
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.main_state    = res_main_q;
  assign out_o.step_code     = res_sub_q;
  assign out_o.play_accepted = res_acc_q;
  assign out_o.command_valid = res_cmd_v_q;
  assign out_o.command_code  = res_cmd_q;
  assign out_o.play_time_ms  = res_pt_q;

endmodule

/* rtl/mps_checker.sv */
module mps_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [2:0] main_state_i,
  input logic [3:0] step_code_i,
  input logic       play_accepted_i,
  input logic       command_valid_i,
  input logic [1:0] command_code_i
);

  // every transfer in gives a result in the next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> out_valid_i)
    else $error("no result after input transfer");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_code_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !command_valid_i |-> command_code_i == mps_pkg::CMD_SERVO_ON)
    else $error("command code set without command");

  // each servo command starts a timed wait
  a_cmd_delay: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && command_valid_i |-> step_code_i == mps_pkg::SUB_DELAY)
    else $error("servo command without delay");

  a_play_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && play_accepted_i |->
      main_state_i == mps_pkg::MAIN_READY_PLAY || main_state_i == mps_pkg::MAIN_PLAY)
    else $error("play accepted outside play modes");

endmodule

bind motion_platform_sequencer_core mps_checker u_mps_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .main_state_i    (out_o.main_state),
  .step_code_i     (out_o.step_code),
  .play_accepted_i (out_o.play_accepted),
  .command_valid_i (out_o.command_valid),
  .command_code_i  (out_o.command_code)
);

/* tb/sv/tb_motion_platform_sequencer_core.sv */
`timescale 1ns / 100ps

module tb_motion_platform_sequencer_core;
  import mps_pkg::*;

  localparam int unsigned ItemTarget = 700;
  localparam int unsigned StallLimit = 2000;
  localparam int unsigned StageTicks = 160;
  localparam int unsigned HoldCycles = 150;
  localparam logic [ElapsedW-1:0] MaxElapsed = 10'd1000;

  localparam logic [FuncW-1:0]   FuncSpare    = 3'd7;
  localparam logic [CfgIdxW-1:0] CfgIdxSpare0 = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgIdxSpare1 = 3'd7;

  typedef struct packed {
    logic [2:0]          main_state;
    logic [3:0]          step_code;
    logic                play_accepted;
    logic                command_valid;
    logic [1:0]          command_code;
    logic [OutTimeW-1:0] play_time_ms;
  } step_result_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgW-1:0]     cfg_data_i;

  mps_in_if  in_if ();
  mps_out_if out_if ();

  motion_platform_sequencer_core u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // sequencer state as the testbench sees it
  main_e               seq_mode;
  sub_e                seq_step;
  sub_e                seq_delay_next;
  longint              seq_delay_left;
  logic [OutTimeW-1:0] seq_play_ms;
  logic [CfgW-1:0]     seq_wait_ms [6];

  step_result_t        expected_results [$];
  int unsigned         failures;
  int unsigned         items_sent;
  int unsigned         quiet_cycles;
  int unsigned         hold_request;
  bit                  src_gaps;
  bit                  sink_stalls;

  function automatic void arm_delay(logic [CfgW-1:0] ms, sub_e next);
    seq_step       = SUB_DELAY;
    seq_delay_left = longint'(ms);
    seq_delay_next = next;
  endfunction

  function automatic void enter_ready_stop();
    seq_mode    = MAIN_READY_STOP;
    seq_step    = SUB_ORIGIN_STOP;
    seq_play_ms = '0;
  endfunction

  function automatic step_result_t advance_sequencer(logic [FuncW-1:0]    func,
                                                     logic [ElapsedW-1:0] elapsed);
    step_result_t r;
    logic [OutTimeW:0] sum;
    r = '0;
    case (func)
      FUNC_TICK: begin
        case (seq_step)
          SUB_OFF:          seq_mode = MAIN_OFF;
          SUB_START_MOTION: seq_step = SUB_INIT;
          SUB_INIT: begin
            r.command_valid = 1'b1;
            r.command_code  = CMD_SERVO_ON;
            arm_delay(seq_wait_ms[CFG_SERVO_ON_WAIT], SUB_STOP_READY);
          end
          SUB_START: begin
            seq_mode        = MAIN_READY_PLAY;
            r.command_valid = 1'b1;
            r.command_code  = CMD_START;
            arm_delay(seq_wait_ms[CFG_START_WAIT], SUB_PLAYING);
          end
          SUB_ORIGIN:      arm_delay('0, SUB_READY);
          SUB_ORIGIN_STOP: arm_delay(seq_wait_ms[CFG_ORIGIN_WAIT], SUB_STOP_READY);
          SUB_STOP_READY: begin
            r.command_valid = 1'b1;
            r.command_code  = CMD_STOP;
            arm_delay(seq_wait_ms[CFG_STOP_WAIT], SUB_READY);
          end
          SUB_READY: seq_mode = MAIN_READY;
          SUB_LOAD:  arm_delay(seq_wait_ms[CFG_START_WAIT], SUB_START);
          SUB_PLAYING: begin
            seq_mode    = MAIN_PLAY;
            sum         = {1'b0, seq_play_ms} + (OutTimeW + 1)'(elapsed);
            seq_play_ms = sum[OutTimeW] ? '1 : sum[OutTimeW-1:0];
          end
          SUB_END: arm_delay(seq_wait_ms[CFG_END_WAIT], SUB_END_STOP);
          SUB_END_STOP: begin
            r.command_valid = 1'b1;
            r.command_code  = CMD_STOP;
            arm_delay(seq_wait_ms[CFG_STOP_WAIT], SUB_STOP);
          end
          SUB_STOP_MOTION: seq_step = SUB_END;
          SUB_STOP: begin
            r.command_valid = 1'b1;
            r.command_code  = CMD_SERVO_OFF;
            arm_delay(seq_wait_ms[CFG_SERVO_OFF_WAIT], SUB_OFF);
          end
          SUB_DELAY: begin
            // leaves only once the remaining time is strictly negative
            seq_delay_left = seq_delay_left - longint'(elapsed);
            if (seq_delay_left < 0) seq_step = seq_delay_next;
          end
          default: ;
        endcase
      end
      FUNC_ON: begin
        seq_mode = MAIN_INIT;
        seq_step = SUB_START_MOTION;
      end
      FUNC_READY: enter_ready_stop();
      FUNC_READY_NO_ORIGIN: begin
        seq_play_ms = '0;
        arm_delay(seq_wait_ms[CFG_START_WAIT], SUB_STOP_READY);
      end
      FUNC_PLAY: begin
        case (seq_mode)
          MAIN_READY_PLAY: r.play_accepted = 1'b1;
          MAIN_READY_STOP: begin
            // moves on to start but still answers not accepted
            seq_mode = MAIN_READY_PLAY;
            seq_step = SUB_START;
          end
          MAIN_PLAY: begin
            if (seq_step == SUB_DELAY) seq_step = SUB_START;
            r.play_accepted = 1'b1;
          end
          MAIN_READY: begin
            seq_mode        = MAIN_READY_PLAY;
            seq_step        = SUB_START;
            r.play_accepted = 1'b1;
          end
          default: ;
        endcase
      end
      FUNC_STOP: begin
        if (seq_mode == MAIN_READY_PLAY || seq_mode == MAIN_PLAY) enter_ready_stop();
      end
      FUNC_OFF: begin
        seq_mode = MAIN_END;
        seq_step = SUB_STOP_MOTION;
      end
      default: ;
    endcase
    r.main_state   = seq_mode;
    r.step_code    = seq_step;
    r.play_time_ms = seq_play_ms;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endfunction

  function automatic logic [ElapsedW-1:0] rand_elapsed();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return MaxElapsed;
      default: return ElapsedW'($urandom_range(1, MaxElapsed));
    endcase
  endfunction

  function automatic logic [CfgW-1:0] rand_wait();
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return '1;
      default: return CfgW'($urandom_range(0, 3000));
    endcase
  endfunction

  // valid is left high after a transfer; a gap or a drain lowers it
  task automatic send_item(logic [FuncW-1:0] func, logic [ElapsedW-1:0] elapsed);
    int unsigned gap;
    gap = src_gaps ? $urandom_range(0, 11) : 0;
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.func       <= func;
    in_if.elapsed_ms <= elapsed;
    do @(posedge clk_i); while (!in_if.ready);
    expected_results.push_back(advance_sequencer(func, elapsed));
    items_sent++;
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // leaves the write enable high; the caller lowers it after the last write
  task automatic write_cfg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    if (idx <= CFG_SERVO_OFF_WAIT) seq_wait_ms[idx] = data;
  endtask

  task automatic set_waits(logic [CfgW-1:0] on_ms, start_ms, origin_ms, stop_ms, end_ms,
                           off_ms);
    write_cfg(CFG_SERVO_ON_WAIT, on_ms);
    write_cfg(CFG_START_WAIT, start_ms);
    write_cfg(CFG_ORIGIN_WAIT, origin_ms);
    write_cfg(CFG_STOP_WAIT, stop_ms);
    write_cfg(CFG_END_WAIT, end_ms);
    write_cfg(CFG_SERVO_OFF_WAIT, off_ms);
    cfg_we_i <= 1'b0;
  endtask

  task automatic tick_until(sub_e target, int unsigned max_ticks);
    for (int unsigned n = 0; n < max_ticks && seq_step != target; n++)
      send_item(FUNC_TICK, rand_elapsed());
  endtask

  task automatic test_power_up_and_play();
    send_item(FUNC_TICK, MaxElapsed);
    send_item(FuncSpare, MaxElapsed);
    send_item(FUNC_ON, '0);
    send_item(FUNC_TICK, '0);
    send_item(FUNC_TICK, '0);
    send_item(FUNC_TICK, '0);
    send_item(FUNC_TICK, MaxElapsed);
    send_item(FUNC_TICK, 10'd1);
    repeat (5) send_item(FUNC_TICK, MaxElapsed);
    send_item(FUNC_TICK, 10'd7);
    send_item(FUNC_PLAY, '0);
    send_item(FUNC_TICK, '0);
    send_item(FUNC_TICK, 10'd101);
    send_item(FUNC_TICK, MaxElapsed);
    send_item(FUNC_PLAY, '0);
    // ready-without-origin while playing leaves main in play with a delay pending
    send_item(FUNC_READY_NO_ORIGIN, '0);
    send_item(FUNC_PLAY, '0);
    send_item(FUNC_STOP, '0);
    send_item(FUNC_PLAY, MaxElapsed);
    send_item(FUNC_READY, '0);
    send_item(FUNC_OFF, '0);
  endtask

  task automatic test_wait_extremes();
    wait_drained();
    set_waits('0, '0, '0, '0, '0, '0);
    // spare indexes must not disturb anything
    write_cfg(CfgIdxSpare0, '1);
    write_cfg(CfgIdxSpare1, '1);
    cfg_we_i <= 1'b0;
    tick_until(SUB_OFF, StageTicks);
    send_item(FUNC_TICK, rand_elapsed());
    send_item(FUNC_STOP, '0);
    send_item(FUNC_PLAY, '0);
    wait_drained();
    set_waits('1, '1, '1, '1, '1, '1);
    send_item(FUNC_ON, MaxElapsed);
    tick_until(SUB_STOP_READY, StageTicks);
  endtask

  task automatic test_output_backpressure();
    wait_drained();
    src_gaps    = 1'b0;
    sink_stalls = 1'b0;
    hold_request = HoldCycles;
    send_item(FUNC_OFF, '0);
    repeat (30) send_item(FUNC_TICK, rand_elapsed());
    wait_drained();
  endtask

  task automatic test_sender_pause();
    src_gaps    = 1'b1;
    sink_stalls = 1'b1;
    repeat (10) send_item(FUNC_TICK, rand_elapsed());
    wait_drained();
    repeat (10) send_item(FuncW'($urandom_range(0, 7)), rand_elapsed());
    wait_drained();
  endtask

  task automatic run_session();
    send_item(FUNC_ON, ElapsedW'($urandom_range(0, MaxElapsed)));
    tick_until(SUB_READY, StageTicks);
    send_item(FUNC_TICK, rand_elapsed());
    repeat ($urandom_range(1, 3)) begin
      send_item(FUNC_PLAY, ElapsedW'($urandom_range(0, MaxElapsed)));
      tick_until(SUB_PLAYING, StageTicks);
      repeat ($urandom_range(2, 12)) begin
        if ($urandom_range(0, 6) == 0) begin
          send_item(FuncW'($urandom_range(0, 7)), rand_elapsed());
        end else begin
          send_item(FUNC_TICK, rand_elapsed());
        end
      end
      case ($urandom_range(0, 2))
        0:       send_item(FUNC_STOP, ElapsedW'($urandom_range(0, MaxElapsed)));
        1:       send_item(FUNC_READY, ElapsedW'($urandom_range(0, MaxElapsed)));
        default: send_item(FUNC_READY_NO_ORIGIN, ElapsedW'($urandom_range(0, MaxElapsed)));
      endcase
      tick_until(SUB_READY, StageTicks);
    end
    send_item(FUNC_OFF, ElapsedW'($urandom_range(0, MaxElapsed)));
    tick_until(SUB_OFF, StageTicks);
    send_item(FUNC_TICK, rand_elapsed());
  endtask

  task automatic test_random_sessions();
    while (items_sent < ItemTarget) begin
      wait_drained();
      src_gaps    = ($urandom_range(0, 3) != 0);
      sink_stalls = ($urandom_range(0, 3) != 0);
      set_waits(rand_wait(), rand_wait(), rand_wait(), rand_wait(), rand_wait(), rand_wait());
      repeat ($urandom_range(1, 3)) begin
        if (items_sent < ItemTarget) run_session();
      end
    end
    wait_drained();
  endtask

  initial begin : result_sink
    int unsigned stall;
    out_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_request != 0) begin
        out_if.ready <= 1'b0;
        repeat (hold_request) @(posedge clk_i);
        hold_request = 0;
      end
      stall = sink_stalls ? $urandom_range(0, 11) : 0;
      if (stall != 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
    end
  end

  always @(posedge clk_i) begin : result_check
    step_result_t want;
    if (rst_ni === 1'b1) begin
      if (out_if.valid && out_if.ready) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with nothing pending: main_state %0d step_code %0d",
                 out_if.main_state, out_if.step_code);
          failures++;
        end else begin
          want = expected_results.pop_front();
          check_field("main_state", 32'(want.main_state), 32'(out_if.main_state));
          check_field("step_code", 32'(want.step_code), 32'(out_if.step_code));
          check_field("play_accepted", 32'(want.play_accepted), 32'(out_if.play_accepted));
          check_field("command_valid", 32'(want.command_valid), 32'(out_if.command_valid));
          check_field("command_code", 32'(want.command_code), 32'(out_if.command_code));
          check_field("play_time_ms", want.play_time_ms, out_if.play_time_ms);
        end
      end
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("motion_platform_sequencer_core verification failed");
        $finish;
      end
    end
  end

  initial begin
    failures     = 0;
    items_sent   = 0;
    quiet_cycles = 0;
    hold_request = 0;
    src_gaps     = 1'b1;
    sink_stalls  = 1'b1;
    rst_ni           <= 1'b0;
    cfg_we_i         <= 1'b0;
    cfg_idx_i        <= '0;
    cfg_data_i       <= '0;
    in_if.valid      <= 1'b0;
    in_if.func       <= FUNC_TICK;
    in_if.elapsed_ms <= '0;

    seq_mode       = MAIN_OFF;
    seq_step       = SUB_OFF;
    seq_delay_next = SUB_OFF;
    seq_delay_left = 0;
    seq_play_ms    = '0;
    seq_wait_ms[CFG_SERVO_ON_WAIT]  = ServoOnWaitRst;
    seq_wait_ms[CFG_START_WAIT]     = StartWaitRst;
    seq_wait_ms[CFG_ORIGIN_WAIT]    = OriginWaitRst;
    seq_wait_ms[CFG_STOP_WAIT]      = StopWaitRst;
    seq_wait_ms[CFG_END_WAIT]       = EndWaitRst;
    seq_wait_ms[CFG_SERVO_OFF_WAIT] = ServoOffWaitRst;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_power_up_and_play();
    test_wait_extremes();
    test_output_backpressure();
    test_sender_pause();
    test_random_sessions();

    wait_drained();
    if (expected_results.size() != 0) begin
      $error("%0d results never arrived", expected_results.size());
      failures++;
    end
    if (failures == 0) begin
      $display("motion_platform_sequencer_core verification clean");
    end else begin
      $display("motion_platform_sequencer_core verification failed");
    end
    $finish;
  end

endmodule
